### src/bfpa_pkg.sv
// Package for the best-fit partition allocator.
// Holds field widths, action codes, parameter defaults and the fit-unit control type.
// No dependencies; the other files, except bfpa_ram, use it by scoped names.
package bfpa_pkg;

	localparam int PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int IDX_BITS     = 4;
	localparam int SIZE_IN_BITS = 16;
	localparam int LEFT_BITS    = 16;
	localparam int CFG_BITS     = 5;

	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

	typedef struct packed {
		logic clear;
		logic sample;
	} fit_ctl_t;

endpackage

### src/bfpa_if.sv
// Handshake interfaces for the request and response channels of the allocator.
// Depends on bfpa_pkg for payload widths.
interface bfpa_req_if;
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic [bfpa_pkg::IDX_BITS-1:0]     partition_index;
	logic [bfpa_pkg::SIZE_IN_BITS-1:0] size;

	modport source (output valid, action, partition_index, size, input ready);
	modport sink (input valid, action, partition_index, size, output ready);
endinterface

interface bfpa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           granted;
	logic [bfpa_pkg::IDX_BITS-1:0]  chosen_index;
	logic [bfpa_pkg::LEFT_BITS-1:0] leftover;

	modport source (output valid, granted, chosen_index, leftover, input ready);
	modport sink (input valid, granted, chosen_index, leftover, output ready);
endinterface

### src/bfpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/bfpa_fit.sv
// Shared subtract-and-compare unit; keeps the best free fit seen during a scan.
// Depends on bfpa_pkg for the control struct.
module bfpa_fit #(
	parameter int PARTITIONS = bfpa_pkg::PARTITIONS_DEF,
	parameter int SIZE_BITS  = bfpa_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfpa_pkg::fit_ctl_t            ctl,
	input  logic [SIZE_BITS-1:0]          part_size,
	input  logic [SIZE_BITS-1:0]          req_size,
	input  logic [$clog2(PARTITIONS)-1:0] idx,
	input  logic                          free,
	output logic                          found,
	output logic [$clog2(PARTITIONS)-1:0] best_idx,
	output logic [SIZE_BITS-1:0]          best_left
);

	logic                          found_q;
	logic [$clog2(PARTITIONS)-1:0] best_idx_q;
	logic [SIZE_BITS-1:0]          best_left_q;
	logic [SIZE_BITS:0]            diff;
	logic                          better;

	assign diff   = {1'b0, part_size} - {1'b0, req_size};
	assign better = free && !diff[SIZE_BITS]
		&& (!found_q || (diff[SIZE_BITS-1:0] < best_left_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.sample && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sample && better && !ctl.clear) begin
			best_idx_q  <= idx;
			best_left_q <= diff[SIZE_BITS-1:0];
		end
	end

	assign found     = found_q;
	assign best_idx  = best_idx_q;
	assign best_left = best_left_q;

endmodule

### src/best_fit_partition_allocator.sv
// Best-fit fixed-partition allocator, top level: sequencer, used bits, config, output register.
// Depends on bfpa_pkg, bfpa_if, bfpa_ram and bfpa_fit.
// Load word: accepted while idle, no response. Reset clears used bits and control, sets config (16).
// Allocate word: scans N = min(partitions_in_use, PARTITIONS) entries, one a cycle, through one
// RAM read port and one subtract-compare unit; after a drain state, the EMIT state loads the
// response (from idle when N is 0), later while a prior one waits; idle then takes the next word.
module best_fit_partition_allocator #(
	parameter int PARTITIONS = bfpa_pkg::PARTITIONS_DEF,
	parameter int SIZE_BITS  = bfpa_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bfpa_req_if.sink                        req,
	bfpa_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [bfpa_pkg::CFG_BITS-1:0]   cfg_wdata
);

	localparam int AW = $clog2(PARTITIONS);
	localparam int LW = $clog2(PARTITIONS + 1);
	localparam int CW = (LW > bfpa_pkg::CFG_BITS) ? LW : bfpa_pkg::CFG_BITS;
	localparam int MX = (AW > bfpa_pkg::IDX_BITS) ? AW : bfpa_pkg::IDX_BITS;
	localparam int ZW = MX + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [bfpa_pkg::CFG_BITS-1:0]   cfg_q;
	logic [LW-1:0]                   limit_q;
	logic [AW-1:0]                   cnt_q;
	logic [SIZE_BITS-1:0]            req_size_q;
	logic                            out_valid_q;
	logic                            out_granted_q;
	logic [bfpa_pkg::IDX_BITS-1:0]   out_idx_q;
	logic [bfpa_pkg::LEFT_BITS-1:0]  out_left_q;
	logic                            rd_valid_s1;
	logic [AW-1:0]                   rd_idx_s1;
	logic [PARTITIONS-1:0]           used_q;

	logic                            accept;
	logic                            load_hit;
	logic [ZW-1:0]                   load_idx;
	logic [AW-1:0]                   waddr;
	logic [SIZE_BITS-1:0]            in_size;
	logic [SIZE_BITS-1:0]            rd_data;
	logic [CW-1:0]                   cfg_ext;
	logic [CW-1:0]                   lim;
	logic                            last_issue;
	logic                            out_load;
	bfpa_pkg::fit_ctl_t              fit_ctl;
	logic                            fit_found;
	logic [AW-1:0]                   fit_best_idx;
	logic [SIZE_BITS-1:0]            fit_best_left;

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign in_size    = SIZE_BITS'(req.size);
	assign load_idx   = ZW'(req.partition_index);
	assign load_hit   = accept && (req.action == bfpa_pkg::ACT_LOAD)
		&& (load_idx < ZW'(PARTITIONS));
	assign waddr      = load_idx[AW-1:0];
	assign cfg_ext    = CW'(cfg_q);
	assign lim        = (cfg_ext > CW'(PARTITIONS)) ? CW'(PARTITIONS) : cfg_ext;
	assign last_issue = ((LW'(cnt_q) + LW'(1)) == limit_q);
	assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	assign fit_ctl.clear  = accept && (req.action == bfpa_pkg::ACT_ALLOC);
	assign fit_ctl.sample = rd_valid_s1;

	bfpa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(PARTITIONS)
	) u_size_ram (
		.clk   (clk),
		.we    (load_hit),
		.waddr (waddr),
		.wdata (in_size),
		.raddr (cnt_q),
		.rdata (rd_data)
	);

	bfpa_fit #(
		.PARTITIONS(PARTITIONS),
		.SIZE_BITS (SIZE_BITS)
	) u_fit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fit_ctl),
		.part_size (rd_data),
		.req_size  (req_size_q),
		.idx       (rd_idx_s1),
		.free      (!used_q[rd_idx_s1]),
		.found     (fit_found),
		.best_idx  (fit_best_idx),
		.best_left (fit_best_left)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bfpa_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (load_hit) begin
			used_q[waddr] <= 1'b0;
		end else if (out_load && fit_found) begin
			used_q[fit_best_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			limit_q       <= '0;
			req_size_q    <= '0;
			out_valid_q   <= 1'b0;
			out_granted_q <= 1'b0;
			out_idx_q     <= '0;
			out_left_q    <= '0;
		end else begin
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && (req.action == bfpa_pkg::ACT_ALLOC)) begin
						req_size_q <= in_size;
						limit_q    <= LW'(lim);
						state_q    <= (lim == '0) ? ST_EMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						out_granted_q <= fit_found;
						out_idx_q     <= fit_found
							? bfpa_pkg::IDX_BITS'(fit_best_idx) : '0;
						out_left_q    <= fit_found
							? bfpa_pkg::LEFT_BITS'(fit_best_left) : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.granted      = out_granted_q;
	assign rsp.chosen_index = out_idx_q;
	assign rsp.leftover     = out_left_q;

	a_grant_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && fit_found) |=> used_q[$past(fit_best_idx)])
		else $error("granted partition not marked used");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_granted_q) |-> (out_idx_q == '0 && out_left_q == '0))
		else $error("refused word carries nonzero fields");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (LW'(cnt_q) < limit_q))
		else $error("scan address beyond partitions in use");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("read data sampled outside a scan");

endmodule

### tb/sv/best_fit_partition_allocator_tb.sv
// Testbench for best_fit_partition_allocator: loads partition sizes, requests allocations
// and checks every grant against a scoreboard that tracks the partition table itself.
// Depends on bfpa_pkg, bfpa_if and the allocator RTL.
`timescale 1ns / 1ps

class grant_scoreboard;
	typedef struct {
		logic                              granted;
		logic [bfpa_pkg::IDX_BITS-1:0]     chosen;
		logic [bfpa_pkg::LEFT_BITS-1:0]    left;
	} grant_t;

	bit [bfpa_pkg::SIZE_IN_BITS-1:0] part_size [bfpa_pkg::PARTITIONS_DEF];
	bit                              part_used [bfpa_pkg::PARTITIONS_DEF];
	bit [bfpa_pkg::CFG_BITS-1:0]     in_use;
	grant_t                          pending [$];
	int                              errors;
	int                              loads;
	int                              allocs;
	int                              grants;
	int                              refusals;

	function new();
		in_use = bfpa_pkg::CFG_RESET;
		foreach (part_size[i]) begin
			part_size[i] = '0;
			part_used[i] = 1'b0;
		end
		errors = 0;
		loads = 0;
		allocs = 0;
		grants = 0;
		refusals = 0;
	endfunction

	function void set_in_use(bit [bfpa_pkg::CFG_BITS-1:0] value);
		in_use = value;
	endfunction

	function void note_word(logic act, logic [bfpa_pkg::IDX_BITS-1:0] idx,
			logic [bfpa_pkg::SIZE_IN_BITS-1:0] sz);
		grant_t                          g;
		int                              limit;
		bit                              found;
		bit [bfpa_pkg::LEFT_BITS-1:0]    best_left;
		bit [bfpa_pkg::LEFT_BITS-1:0]    left;
		int                              best_idx;
		if (act == bfpa_pkg::ACT_LOAD) begin
			part_size[idx] = sz;
			part_used[idx] = 1'b0;
			loads++;
			return;
		end
		allocs++;
		limit = (in_use > bfpa_pkg::PARTITIONS_DEF) ? bfpa_pkg::PARTITIONS_DEF : in_use;
		found = 1'b0;
		best_left = '0;
		best_idx = 0;
		for (int i = 0; i < limit; i++) begin
			if (!part_used[i] && part_size[i] >= sz) begin
				left = part_size[i] - sz;
				if (!found || left < best_left) begin
					found = 1'b1;
					best_left = left;
					best_idx = i;
				end
			end
		end
		if (found) begin
			part_used[best_idx] = 1'b1;
			g.granted = 1'b1;
			g.chosen = best_idx[bfpa_pkg::IDX_BITS-1:0];
			g.left = best_left;
			grants++;
		end else begin
			g.granted = 1'b0;
			g.chosen = '0;
			g.left = '0;
			refusals++;
		end
		pending.push_back(g);
	endfunction

	function void check_grant(logic granted, logic [bfpa_pkg::IDX_BITS-1:0] chosen,
			logic [bfpa_pkg::LEFT_BITS-1:0] left);
		grant_t g;
		if (pending.size() == 0) begin
			$display("%0t: response with none expected: granted=%0d index=%0d leftover=%0d",
				$time, granted, chosen, left);
			errors++;
			return;
		end
		g = pending.pop_front();
		if (granted !== g.granted) begin
			$display("%0t: granted mismatch: expected %0d actual %0d", $time, g.granted, granted);
			errors++;
		end
		if (chosen !== g.chosen) begin
			$display("%0t: chosen_index mismatch: expected %0d actual %0d",
				$time, g.chosen, chosen);
			errors++;
		end
		if (left !== g.left) begin
			$display("%0t: leftover mismatch: expected %0d actual %0d", $time, g.left, left);
			errors++;
		end
	endfunction
endclass

module best_fit_partition_allocator_tb;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 58;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bfpa_pkg::CFG_BITS-1:0]   cfg_wdata;
	int                              cycle_count = 0;
	int                              burst_left = 0;
	int                              settings_done = 0;
	bit                              calm = 1'b0;
	grant_scoreboard                 sb;

	bfpa_req_if req_ch ();
	bfpa_rsp_if rsp_ch ();

	best_fit_partition_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_in_use(cfg_wdata);
			if (req_ch.valid && req_ch.ready)
				sb.note_word(req_ch.action, req_ch.partition_index, req_ch.size);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_grant(rsp_ch.granted, rsp_ch.chosen_index, rsp_ch.leftover);
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				rsp_ch.ready = 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 20);
			end
		end
	end

	task automatic send_word(input logic act, input logic [bfpa_pkg::IDX_BITS-1:0] idx,
			input logic [bfpa_pkg::SIZE_IN_BITS-1:0] sz);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.partition_index = idx;
		req_ch.size = sz;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
	endtask

	task automatic drain_all();
		@(negedge clk);
		req_ch.valid = 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_in_use(input logic [bfpa_pkg::CFG_BITS-1:0] value);
		drain_all();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		settings_done++;
	endtask

	function automatic logic [bfpa_pkg::SIZE_IN_BITS-1:0] pick_size();
		logic [bfpa_pkg::SIZE_IN_BITS-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = bfpa_pkg::SIZE_IN_BITS'($urandom_range(0, 40));
			2, 3: v = bfpa_pkg::SIZE_IN_BITS'($urandom);
			4: begin
				case ($urandom_range(0, 3))
					0: v = 16'h0000;
					1: v = 16'hFFFF;
					2: v = 16'h8000;
					default: v = 16'h7FFF;
				endcase
			end
			default: v = bfpa_pkg::SIZE_IN_BITS'($urandom_range(65500, 65535));
		endcase
		return v;
	endfunction

	initial begin
		logic [bfpa_pkg::SIZE_IN_BITS-1:0] load_plan [bfpa_pkg::PARTITIONS_DEF];
		int                                in_use_plan [10];
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.action = bfpa_pkg::ACT_LOAD;
		req_ch.partition_index = '0;
		req_ch.size = '0;
		load_plan = '{16'd100, 16'hFFFF, 16'd0, 16'd100, 16'd50, 16'h8000, 16'h7FFF, 16'd1,
			16'd200, 16'd300, 16'd400, 16'd500, 16'd600, 16'd700, 16'd800, 16'hFFFF};
		in_use_plan = '{16, 1, 0, 31, 5, 17, 2, 16, 9, 31};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// fill the whole table first so no allocate ever sees an unwritten entry
		for (int i = 0; i < bfpa_pkg::PARTITIONS_DEF; i++)
			send_word(bfpa_pkg::ACT_LOAD, i[bfpa_pkg::IDX_BITS-1:0], load_plan[i]);
		send_word(bfpa_pkg::ACT_ALLOC, 4'hF, 16'd0);
		send_word(bfpa_pkg::ACT_ALLOC, 4'h0, 16'hFFFF);
		send_word(bfpa_pkg::ACT_ALLOC, 4'h5, 16'd100);
		send_word(bfpa_pkg::ACT_ALLOC, 4'hA, 16'd100);
		send_word(bfpa_pkg::ACT_ALLOC, 4'h3, 16'hFFFF);
		send_word(bfpa_pkg::ACT_ALLOC, 4'hC, 16'hFFFF);
		send_word(bfpa_pkg::ACT_LOAD, 4'h1, 16'hFFFF);

		for (int p = 0; p < 10; p++) begin
			write_in_use(in_use_plan[p][bfpa_pkg::CFG_BITS-1:0]);
			calm = (p % 4 == 3);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == PHASE_WORDS / 2 && $urandom_range(0, 1) == 0)
					drain_all();
				if ($urandom_range(0, 99) < 38)
					send_word(bfpa_pkg::ACT_LOAD,
						bfpa_pkg::IDX_BITS'($urandom_range(0, 15)), pick_size());
				else
					send_word(bfpa_pkg::ACT_ALLOC,
						bfpa_pkg::IDX_BITS'($urandom_range(0, 15)), pick_size());
			end
		end
		calm = 1'b0;

		drain_all();
		repeat (20) @(posedge clk);
		$display("Ran %0d loads and %0d allocations across %0d partition-count settings",
			sb.loads, sb.allocs, settings_done);
		$display("Allocations granted: %0d, refused: %0d, mismatches: %0d",
			sb.grants, sb.refusals, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
